[src/assert_macros.svh]
// Assertion macros, included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication checked at every rising edge, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true while out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[src/lcs_pkg.sv]
// Types and constants of the linear contrast stretch.
package lcs_pkg;

    localparam int PIXEL_BITS = 8;
    localparam logic [PIXEL_BITS-1:0] MAXV = {PIXEL_BITS{1'b1}};

    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_MAP     = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [PIXEL_BITS-1:0] pixel;
        logic                  last;
    } t_in_item;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] level;
        logic                  clipped;
    } t_out_item;

    // Measured range, seen by the top level for checking.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] low;
        logic [PIXEL_BITS-1:0] high;
        logic                  restart;
    } t_range;

    // One slot of the divider chain.
    typedef struct packed {
        logic                  valid;
        logic                  force_out;  // level does not come from the quotient
        logic                  force_max;  // forced level is MAXV, else 0
        logic                  clip;
        logic [PIXEL_BITS-1:0] rem;        // partial remainder, below den unless the level is forced
        logic [PIXEL_BITS-1:0] den;
        logic [PIXEL_BITS-1:0] bits;       // numerator low bits in, quotient bits out
    } t_stage;

endpackage

[src/lcs_front.sv]
// Min/max tracker and head cell that seeds the divider chain.
module lcs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_advance,
    input  lcs_pkg::t_in_item i_item,
    output lcs_pkg::t_range   o_range,
    output lcs_pkg::t_stage   o_stage
);
    import lcs_pkg::*;

    logic [PIXEL_BITS-1:0]   r_low, n_low;
    logic [PIXEL_BITS-1:0]   r_high, n_high;
    logic                    r_restart, n_restart;
    t_stage                  r_stage, n_stage;
    logic                    above, below, spread;
    logic [PIXEL_BITS-1:0]   delta;
    logic [2*PIXEL_BITS-1:0] num;

    always_comb begin
        n_low     = r_low;
        n_high    = r_high;
        n_restart = r_restart;
        if (i_accept && i_item.cmd == CMD_MEASURE) begin
            if (r_restart) begin
                n_low     = i_item.pixel;
                n_high    = i_item.pixel;
                n_restart = 1'b0;
            end else begin
                if (i_item.pixel < r_low) begin
                    n_low = i_item.pixel;
                end
                if (i_item.pixel > r_high) begin
                    n_high = i_item.pixel;
                end
            end
            if (i_item.last) begin
                n_restart = 1'b1;
            end
        end
    end

    // num = MAXV * (p - low) = (d << N) - d
    always_comb begin
        above  = i_item.pixel > r_high;
        below  = i_item.pixel < r_low;
        spread = r_high > r_low;
        delta  = i_item.pixel - r_low;
        num    = {delta, {PIXEL_BITS{1'b0}}} - {{PIXEL_BITS{1'b0}}, delta};

        n_stage.valid     = i_accept && i_item.cmd == CMD_MAP;
        n_stage.force_out = !spread || above || below;
        n_stage.force_max = spread && above;
        n_stage.clip      = above || below;
        n_stage.rem       = num[2*PIXEL_BITS-1:PIXEL_BITS];
        n_stage.den       = r_high - r_low;
        n_stage.bits      = num[PIXEL_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low     <= MAXV;
            r_high    <= '0;
            r_restart <= 1'b1;
        end else begin
            r_low     <= n_low;
            r_high    <= n_high;
            r_restart <= n_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_advance) begin
            r_stage.valid <= n_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_stage.force_out <= n_stage.force_out;
            r_stage.force_max <= n_stage.force_max;
            r_stage.clip      <= n_stage.clip;
            r_stage.rem       <= n_stage.rem;
            r_stage.den       <= n_stage.den;
            r_stage.bits      <= n_stage.bits;
        end
    end

    assign o_range = '{low: r_low, high: r_high, restart: r_restart};
    assign o_stage = r_stage;

endmodule

[src/lcs_cell.sv]
// One restoring-division cell: produces one quotient bit per slot.
module lcs_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  lcs_pkg::t_stage i_stage,
    output lcs_pkg::t_stage o_stage
);
    import lcs_pkg::*;

    t_stage                r_stage, n_stage;
    logic [PIXEL_BITS:0]   trial;
    logic [PIXEL_BITS:0]   diff;
    logic                  fits;

    always_comb begin
        trial   = {i_stage.rem, i_stage.bits[PIXEL_BITS-1]};
        diff    = trial - {1'b0, i_stage.den};
        fits    = trial >= {1'b0, i_stage.den};
        n_stage = i_stage;
        n_stage.rem  = fits ? diff[PIXEL_BITS-1:0] : trial[PIXEL_BITS-1:0];
        n_stage.bits = {i_stage.bits[PIXEL_BITS-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_advance) begin
            r_stage.valid <= n_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_stage.force_out <= n_stage.force_out;
            r_stage.force_max <= n_stage.force_max;
            r_stage.clip      <= n_stage.clip;
            r_stage.rem       <= n_stage.rem;
            r_stage.den       <= n_stage.den;
            r_stage.bits      <= n_stage.bits;
        end
    end

    assign o_stage = r_stage;

endmodule

[src/linear_contrast_stretch.sv]
// Top level of the linear contrast stretch: tracker, divider chain, output register.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------------
//  in      | to block  | i_in_valid  / o_in_stall    | t_in_item  {cmd,pixel,last}
//  out     | from block| o_out_valid / i_out_stall   | t_out_item {level,clipped}
//
//  One pixel per clock while not stalled. A map pixel's result passes, after
//  acceptance, one head cell, PIXEL_BITS divider cells (one quotient bit
//  each) and one output register. That chain length sets the latency.
//  Measure pixels update min/max in the cycle they are accepted and make no
//  result. Reset (synchronous, active low) empties the chain and restores
//  min = MAXV, max = 0, restart pending. A stall on the output, while the
//  output register is full, freezes the whole chain and stalls the input.
module linear_contrast_stretch (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lcs_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lcs_pkg::t_out_item o_out_data
);
    import lcs_pkg::*;

    `include "assert_macros.svh"

    t_stage    chain [PIXEL_BITS+1];   // chain[0] from head cell, chain[k] after k bits
    t_range    range;
    logic      advance;
    logic      accept;
    logic      r_out_valid;
    t_out_item r_out_data, n_out_data;
    t_stage    tail;

    // The chain moves whenever the output register is empty or being drained.
    assign advance = !r_out_valid || !i_out_stall;
    assign accept  = i_in_valid && advance;

    lcs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_advance (advance),
        .i_item    (i_in_data),
        .o_range   (range),
        .o_stage   (chain[0])
    );

    for (genvar k = 0; k < PIXEL_BITS; k++) begin : g_cell
        lcs_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (advance),
            .i_stage   (chain[k]),
            .o_stage   (chain[k+1])
        );
    end

    assign tail = chain[PIXEL_BITS];

    // Flat or empty range and out-of-range pixels bypass the quotient.
    always_comb begin
        n_out_data.clipped = tail.clip;
        if (tail.force_out) begin
            n_out_data.level = tail.force_max ? MAXV : '0;
        end else begin
            n_out_data.level = tail.bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= tail.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_in_stall  = !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Restart: the first measure pixel of an image pins both bounds to it.
    `ASSERT_CLK(a_restart_pins, i_clk, i_rst_n, (accept && i_in_data.cmd == CMD_MEASURE && range.restart) |=> (range.low == $past(i_in_data.pixel) && range.high == $past(i_in_data.pixel)), "restart did not pin bounds")
    // Once an image has been measured, the range is never inverted.
    `ASSERT_NEVER(a_range_order, i_clk, i_rst_n, !range.restart && range.low > range.high, "min above max")
    // A finished map transaction at the chain's tail lands in the output register.
    `ASSERT_CLK(a_tail_to_out, i_clk, i_rst_n, (tail.valid && advance) |=> o_out_valid, "result lost at tail")

endmodule
